// ===== rtl/clfp_pkg.sv =====
// Shared constants and codes for the CR/LF line framer pool.
package clfp_pkg;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_DONE  = 2'd0;
	localparam kind_t KIND_BYTE  = 2'd1;
	localparam kind_t KIND_EMPTY = 2'd2;

	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] BYTE_CR = 8'h0D;

endpackage

// ===== rtl/clfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module clfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/crlf_line_framer_pool.sv =====
// Top level of the CR/LF line framer: assembles bytes into lines held in a ring of slots.
//
// Usage: a request is taken at a rising edge where start is high and busy is low.
// command selects a push of data_byte or a read-out of the oldest completed line.
// Results appear on the result ports for exactly one cycle, marked by result_valid;
// the receiver cannot hold them off, and none is dropped.
// Push: busy stays low, so pushes may come every cycle.
// A push that completes a line gives one completion notice in the following cycle.
// Read with lines pending: the line RAM is read one byte per cycle through its single
// read port; each byte is registered in the RAM and again at the result ports, and the
// bytes follow one per cycle. Busy stays high until the last byte of the line is read.
// A read with nothing pending gives one result in the cycle after the request.
// Line bytes sit in one RAM, the per-slot lengths in a second small RAM.
// Reset empties the ring: no lines pending, slot zero is the write and read slot.
// The line RAM is not cleared; only bytes that were written are ever read out.
module crlf_line_framer_pool #(
	parameter int LINE_BYTES = 64,
	parameter int POOL_SLOTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [1:0]  slot,
	output logic [5:0]  line_length,
	output logic        last,
	output logic        overrun,
	output logic        more_pending
);

	localparam int LW     = $clog2(LINE_BYTES);
	localparam int SLOT_W = $clog2(POOL_SLOTS);
	localparam int CNT_W  = $clog2(POOL_SLOTS);
	localparam int AW     = SLOT_W + LW;
	localparam int DEPTH  = POOL_SLOTS * (2 ** LW);

	localparam logic [LW-1:0]     MAX_LEN   = LW'(LINE_BYTES - 2);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(POOL_SLOTS - 1);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(POOL_SLOTS - 1);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_STREAM = 1'b1;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_LAST) ? '0 : SLOT_W'(s + 1'b1);
	endfunction

	logic              state_q;
	logic [SLOT_W-1:0] write_slot_q;
	logic [SLOT_W-1:0] read_slot_q;
	logic [CNT_W-1:0]  pending_q;
	logic [LW-1:0]     cur_len_q;
	logic [LW-1:0]     idx_q;

	logic              accept;
	logic              is_push;
	logic              is_eol;
	logic              has_room;
	logic [LW-1:0]     push_len;
	logic              push_done;
	logic              stream_last;

	logic              line_we;
	logic [AW-1:0]     line_waddr;
	logic              line_re;
	logic [AW-1:0]     line_raddr;
	logic [7:0]        line_rd;
	logic              len_we;
	logic              len_re;
	logic [LW-1:0]     len_rd;

	assign busy    = (state_q == ST_STREAM);
	assign accept  = start && !busy;
	assign is_push = (command == clfp_pkg::CMD_PUSH);
	assign is_eol  = (data_byte == clfp_pkg::BYTE_LF) || (data_byte == clfp_pkg::BYTE_CR);
	assign has_room = (cur_len_q < MAX_LEN);

	// A line closes on reaching its maximum length, or on CR/LF after at least one byte.
	always_comb begin
		if (!is_eol) begin
			push_len  = has_room ? LW'(cur_len_q + 1'b1) : cur_len_q;
			push_done = (push_len >= MAX_LEN);
		end else begin
			push_len  = cur_len_q;
			push_done = (cur_len_q != '0);
		end
	end

	assign stream_last = (idx_q == len_rd);

	assign line_we    = accept && is_push && !is_eol && has_room;
	assign line_waddr = {write_slot_q, cur_len_q};
	assign line_re    = (accept && !is_push) || busy;
	assign line_raddr = {read_slot_q, (busy ? idx_q : {LW{1'b0}})};
	assign len_we     = accept && is_push && push_done;
	assign len_re     = accept && !is_push;

	clfp_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_waddr),
		.wdata (data_byte),
		.re    (line_re),
		.raddr (line_raddr),
		.rdata (line_rd)
	);

	clfp_ram #(
		.WIDTH (LW),
		.DEPTH (POOL_SLOTS)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (write_slot_q),
		.wdata (push_len),
		.re    (len_re),
		.raddr (read_slot_q),
		.rdata (len_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			write_slot_q <= '0;
			read_slot_q  <= '0;
			pending_q    <= '0;
			cur_len_q    <= '0;
			idx_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_push) begin
						if (push_done) begin
							write_slot_q <= next_slot(write_slot_q);
							cur_len_q    <= '0;
							result_valid <= 1'b1;
							// The new write slot holds the oldest unread line: drop it.
							if (pending_q == CNT_FULL) begin
								read_slot_q <= next_slot(read_slot_q);
							end else begin
								pending_q <= CNT_W'(pending_q + 1'b1);
							end
						end else begin
							cur_len_q <= push_len;
						end
					end else if (accept) begin
						if (pending_q == '0) begin
							result_valid <= 1'b1;
						end else begin
							state_q <= ST_STREAM;
							idx_q   <= LW'(1);
						end
					end
				end
				ST_STREAM: begin
					result_valid <= 1'b1;
					idx_q        <= LW'(idx_q + 1'b1);
					if (stream_last) begin
						state_q     <= ST_IDLE;
						read_slot_q <= next_slot(read_slot_q);
						pending_q   <= CNT_W'(pending_q - 1'b1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload; qualified by result_valid.
	always_ff @(posedge clk) begin
		if (busy) begin
			kind         <= clfp_pkg::KIND_BYTE;
			out_byte     <= line_rd;
			slot         <= 2'(read_slot_q);
			line_length  <= 6'(len_rd);
			last         <= stream_last;
			overrun      <= 1'b0;
			more_pending <= (pending_q > CNT_W'(1));
		end else if (is_push) begin
			kind         <= clfp_pkg::KIND_DONE;
			out_byte     <= 8'd0;
			slot         <= 2'(write_slot_q);
			line_length  <= 6'(push_len);
			last         <= 1'b1;
			overrun      <= (pending_q == CNT_FULL);
			more_pending <= 1'b1;
		end else begin
			kind         <= clfp_pkg::KIND_EMPTY;
			out_byte     <= 8'd0;
			slot         <= 2'(read_slot_q);
			line_length  <= 6'd0;
			last         <= 1'b1;
			overrun      <= 1'b0;
			more_pending <= 1'b0;
		end
	end

endmodule

// ===== rtl/clfp_checker.sv =====
// Port-level checks for the CR/LF line framer pool, bound to its top level.
module clfp_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       command,
	input logic       result_valid,
	input logic [1:0] kind,
	input logic [5:0] line_length,
	input logic       last,
	input logic       overrun,
	input logic       more_pending
);

	// A line read-out runs without gaps and releases busy with its final byte.
	a_stream_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == clfp_pkg::KIND_BYTE |-> busy == !last)
		else $error("busy does not track the line read-out");

	a_stream_cont: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == clfp_pkg::KIND_BYTE && !last
		|=> result_valid && kind == clfp_pkg::KIND_BYTE)
		else $error("line read-out broke off before its last byte");

	// A read request either starts a read-out or answers at once.
	a_read_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == clfp_pkg::CMD_READ |=> busy || result_valid)
		else $error("read request got no response");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == clfp_pkg::KIND_DONE || kind == clfp_pkg::KIND_EMPTY)
		|-> last && !(kind == clfp_pkg::KIND_DONE && !more_pending))
		else $error("single-result request marked wrongly");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == clfp_pkg::KIND_EMPTY
		|-> !more_pending && !overrun && line_length == 6'd0)
		else $error("nothing-pending result carries line information");

endmodule

bind crlf_line_framer_pool clfp_port_checker u_clfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.command      (command),
	.result_valid (result_valid),
	.kind         (kind),
	.line_length  (line_length),
	.last         (last),
	.overrun      (overrun),
	.more_pending (more_pending)
);

// ===== dv/clfp_checker.sv =====
// Checker for the CR/LF line framer pool: predicts every result and compares it on arrival.
`timescale 1ns / 1ps
module clfp_checker #(
	parameter int LINE_BYTES = 64,
	parameter int POOL_SLOTS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic       command,
	input  logic [7:0] data_byte,
	input  logic       result_valid,
	input  logic [1:0] kind,
	input  logic [7:0] out_byte,
	input  logic [1:0] slot,
	input  logic [5:0] line_length,
	input  logic       last,
	input  logic       overrun,
	input  logic       more_pending,
	output int         fail_count,
	output int         results_due,
	output int         requests_done,
	output int         results_seen,
	output int         overrun_count,
	output int         full_lines,
	output int         empty_reads
);

	typedef struct packed {
		clfp_pkg::kind_t kind;
		logic [7:0]      data;
		logic [1:0]      slot;
		logic [5:0]      len;
		logic            last;
		logic            overrun;
		logic            more;
	} line_event_t;

	line_event_t line_events_due[$];

	logic [7:0]  ring_bytes [POOL_SLOTS*LINE_BYTES];
	logic [5:0]  ring_len [POOL_SLOTS];
	int unsigned wr_slot;
	int unsigned rd_slot;
	int unsigned lines_waiting;

	task automatic frame_byte(input logic [7:0] b);
		int unsigned ws;
		int unsigned pos;
		int unsigned nw;
		bit          done;
		line_event_t ev;
		requests_done++;
		ws = wr_slot;
		done = 1'b0;
		if (b != clfp_pkg::BYTE_LF && b != clfp_pkg::BYTE_CR) begin
			pos = 32'(ring_len[ws]);
			if (pos < LINE_BYTES - 2) begin
				ring_bytes[ws*LINE_BYTES + pos] = b;
				pos++;
				ring_len[ws] = 6'(pos);
			end
			if (pos >= LINE_BYTES - 2) begin
				done = 1'b1;
				full_lines++;
			end
		end else if (ring_len[ws] != 0) begin
			done = 1'b1;
		end else begin
			// A line ending on an empty slot leaves the ring as it was.
			return;
		end
		if (!done)
			return;
		ev = '{kind: clfp_pkg::KIND_DONE, data: 8'h00, slot: 2'(ws), len: ring_len[ws],
			last: 1'b1, overrun: 1'b0, more: 1'b0};
		nw = (ws + 1) % POOL_SLOTS;
		lines_waiting++;
		if (lines_waiting >= POOL_SLOTS) begin
			// The write slot has caught up with the oldest unread line, which is lost.
			ev.overrun = 1'b1;
			rd_slot = (rd_slot + 1) % POOL_SLOTS;
			lines_waiting = POOL_SLOTS - 1;
			overrun_count++;
		end
		ring_len[nw] = '0;
		wr_slot = nw;
		ev.more = (lines_waiting > 0);
		line_events_due.push_back(ev);
	endtask

	task automatic play_line();
		int unsigned rs;
		int unsigned len;
		logic        more;
		line_event_t ev;
		requests_done++;
		if (lines_waiting == 0) begin
			ev = '{kind: clfp_pkg::KIND_EMPTY, data: 8'h00, slot: 2'(rd_slot), len: 6'd0,
				last: 1'b1, overrun: 1'b0, more: 1'b0};
			line_events_due.push_back(ev);
			empty_reads++;
			return;
		end
		rs = rd_slot;
		len = 32'(ring_len[rs]);
		more = (lines_waiting > 1);
		for (int unsigned i = 0; i < len; i++) begin
			ev = '{kind: clfp_pkg::KIND_BYTE, data: ring_bytes[rs*LINE_BYTES + i],
				slot: 2'(rs), len: 6'(len), last: (i + 1 == len), overrun: 1'b0,
				more: more};
			line_events_due.push_back(ev);
		end
		ring_len[rs] = '0;
		rd_slot = (rs + 1) % POOL_SLOTS;
		lines_waiting--;
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		line_event_t want;
		if (line_events_due.size() == 0) begin
			$error("result arrived with none outstanding: kind %0d slot %0d", kind, slot);
			fail_count++;
			return;
		end
		want = line_events_due.pop_front();
		results_seen++;
		compare_field("kind", 8'(want.kind), 8'(kind));
		compare_field("out_byte", want.data, out_byte);
		compare_field("slot", 8'(want.slot), 8'(slot));
		compare_field("line_length", 8'(want.len), 8'(line_length));
		compare_field("last", 8'(want.last), 8'(last));
		compare_field("overrun", 8'(want.overrun), 8'(overrun));
		compare_field("more_pending", 8'(want.more), 8'(more_pending));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_events_due.delete();
			for (int s = 0; s < POOL_SLOTS; s++)
				ring_len[s] = '0;
			wr_slot = 0;
			rd_slot = 0;
			lines_waiting = 0;
			fail_count = 0;
			results_due = 0;
			requests_done = 0;
			results_seen = 0;
			overrun_count = 0;
			full_lines = 0;
			empty_reads = 0;
		end else begin
			// Results are checked before the new request is predicted, since the last byte
			// of a read can arrive on the same edge that takes the next request.
			if (result_valid)
				check_result();
			if (start && !busy) begin
				if (command == clfp_pkg::CMD_PUSH)
					frame_byte(data_byte);
				else
					play_line();
			end
			results_due = line_events_due.size();
		end
	end

endmodule

// ===== dv/crlf_line_framer_pool_tb.sv =====
// Testbench top for the CR/LF line framer pool: drives requests and gives the verdict.
`timescale 1ns / 1ps
module crlf_line_framer_pool_tb;

	localparam int LINE_BYTES = 64;
	localparam int POOL_SLOTS = 4;
	localparam int REQUEST_TARGET = 480;
	localparam int CYCLE_LIMIT = 250000;
	localparam int SETTLE_CYCLES = 70;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       command = clfp_pkg::CMD_PUSH;
	logic [7:0] data_byte = 8'h00;
	logic       busy;
	logic       result_valid;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [1:0] slot;
	logic [5:0] line_length;
	logic       last;
	logic       overrun;
	logic       more_pending;

	int fail_count;
	int results_due;
	int requests_done;
	int results_seen;
	int overrun_count;
	int full_lines;
	int empty_reads;

	int idle_pct = 14;
	int cycles = 0;

	crlf_line_framer_pool #(
		.LINE_BYTES(LINE_BYTES),
		.POOL_SLOTS(POOL_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.data_byte(data_byte),
		.result_valid(result_valid),
		.kind(kind),
		.out_byte(out_byte),
		.slot(slot),
		.line_length(line_length),
		.last(last),
		.overrun(overrun),
		.more_pending(more_pending)
	);

	clfp_checker #(
		.LINE_BYTES(LINE_BYTES),
		.POOL_SLOTS(POOL_SLOTS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.data_byte(data_byte),
		.result_valid(result_valid),
		.kind(kind),
		.out_byte(out_byte),
		.slot(slot),
		.line_length(line_length),
		.last(last),
		.overrun(overrun),
		.more_pending(more_pending),
		.fail_count(fail_count),
		.results_due(results_due),
		.requests_done(requests_done),
		.results_seen(results_seen),
		.overrun_count(overrun_count),
		.full_lines(full_lines),
		.empty_reads(empty_reads)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles with %0d results outstanding", cycles,
				results_due);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Idle cycles carry random noise on the request fields, which must be ignored.
	task automatic sender_gap();
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			command <= 1'($urandom_range(1));
			data_byte <= 8'($urandom_range(255));
		end
	endtask

	task automatic issue(input logic cmd, input logic [7:0] b);
		sender_gap();
		@(negedge clk);
		start <= 1'b1;
		command <= cmd;
		data_byte <= b;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		start <= 1'b0;
		while (results_due != 0 || busy)
			@(negedge clk);
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == clfp_pkg::BYTE_CR || b == clfp_pkg::BYTE_LF);
		return b;
	endfunction

	task automatic directed_requests();
		logic [7:0] near_breaks [4];
		near_breaks = '{8'h0C, 8'h0E, 8'h09, 8'h0B};
		issue(clfp_pkg::CMD_READ, clfp_pkg::BYTE_LF);
		issue(clfp_pkg::CMD_PUSH, clfp_pkg::BYTE_CR);
		issue(clfp_pkg::CMD_PUSH, clfp_pkg::BYTE_LF);
		issue(clfp_pkg::CMD_PUSH, 8'h00);
		issue(clfp_pkg::CMD_PUSH, 8'hFF);
		issue(clfp_pkg::CMD_PUSH, clfp_pkg::BYTE_CR);
		issue(clfp_pkg::CMD_READ, 8'hFF);
		issue(clfp_pkg::CMD_READ, 8'h00);
		// Four lines with no read in between: the last one pushes the oldest out.
		foreach (near_breaks[i]) begin
			issue(clfp_pkg::CMD_PUSH, near_breaks[i]);
			issue(clfp_pkg::CMD_PUSH, clfp_pkg::BYTE_LF);
		end
		issue(clfp_pkg::CMD_PUSH, clfp_pkg::BYTE_CR);
		repeat (3)
			issue(clfp_pkg::CMD_READ, clfp_pkg::BYTE_CR);
		issue(clfp_pkg::CMD_READ, 8'h55);
	endtask

	task automatic random_scenario();
		int pick;
		int len;
		pick = $urandom_range(99);
		if (pick < 50) begin
			pick = $urandom_range(99);
			if (pick < 6)
				len = LINE_BYTES - 2;
			else if (pick < 16)
				len = $urandom_range(LINE_BYTES - 3, 9);
			else
				len = $urandom_range(8, 1);
			for (int i = 0; i < len; i++)
				issue(clfp_pkg::CMD_PUSH, text_byte());
			// A full line completes by itself; a trailing break then finds an empty slot.
			if (len < LINE_BYTES - 2 || $urandom_range(1)) begin
				case ($urandom_range(2))
					0: issue(clfp_pkg::CMD_PUSH, clfp_pkg::BYTE_CR);
					1: issue(clfp_pkg::CMD_PUSH, clfp_pkg::BYTE_LF);
					default: begin
						issue(clfp_pkg::CMD_PUSH, clfp_pkg::BYTE_CR);
						issue(clfp_pkg::CMD_PUSH, clfp_pkg::BYTE_LF);
					end
				endcase
			end
		end else if (pick < 80) begin
			issue(clfp_pkg::CMD_READ, 8'($urandom_range(255)));
		end else begin
			issue(1'($urandom_range(1)), 8'($urandom_range(255)));
		end
	endtask

	initial begin
		int phase_pct [3];
		phase_pct = '{14, 71, 0};
		repeat (11)
			@(negedge clk);
		arst_n <= 1'b1;
		directed_requests();
		wait_quiet();
		for (int p = 0; p < 3; p++) begin
			idle_pct = phase_pct[p];
			while (requests_done < REQUEST_TARGET * (p + 1) / 3)
				random_scenario();
			wait_quiet();
		end
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		$display("Ran %0d requests giving %0d results, across light, heavy and no sender gaps.",
			requests_done, results_seen);
		$display("Saw %0d full-length lines, %0d overruns and %0d reads of an empty ring.",
			full_lines, overrun_count, empty_reads);
		if (fail_count == 0 && results_due == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
